FILE: design/eo_pkg.sv
// Shared types, widths and constants for the encoder/IMU odometry block.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package eo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CI_W         = $clog2(CORDIC_STEPS);
  localparam int CW           = 34;          // CORDIC datapath width
  localparam int MUL_AW       = 35;
  localparam int MUL_BW       = 32;
  localparam int MUL_PW       = MUL_AW + MUL_BW;
  localparam int MUL_CW       = $clog2(MUL_BW);
  localparam int DIV_NW       = 52;
  localparam int DIV_DW       = 24;
  localparam int DIV_CW       = $clog2(DIV_NW);
  localparam int SAT_W        = 68;

  localparam logic signed [CW-1:0]     CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [MUL_BW-1:0] US_PER_S    = 32'sd1000000;

  typedef struct packed {
    logic               action;
    logic signed [15:0] yaw;
    logic signed [31:0] count_one;
    logic signed [31:0] count_two;
    logic signed [31:0] count_three;
    logic signed [31:0] count_four;
    logic [23:0]        period_us;
  } eo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [31:0] speed;
    logic signed [31:0] yaw_rate;
    logic               period_error;
  } eo_out_t;

  // atan(2^-i), full turn = 2^32
  function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_W'(64'sh7FFFFFFF)) r = 32'sh7FFFFFFF;
    else if (v < -SAT_W'(64'sh80000000)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/eo_mul.sv
// Serial signed multiplier: one multiplier bit per cycle, shift-right accumulate.
// Depends on eo_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none
module eo_mul (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [eo_pkg::MUL_AW-1:0]  a,
  input  wire logic signed [eo_pkg::MUL_BW-1:0]  b,
  output logic                                   done,
  output logic signed [eo_pkg::MUL_PW-1:0]       p
);
  logic signed [eo_pkg::MUL_AW-1:0] a_r;
  logic signed [eo_pkg::MUL_AW:0]   h_r, h_nxt, addend, t;
  logic [eo_pkg::MUL_BW-1:0]        l_r, l_nxt;
  logic [eo_pkg::MUL_CW-1:0]        cnt_r;
  logic                             busy_r, done_r, last;

  assign last = (cnt_r == eo_pkg::MUL_CW'(eo_pkg::MUL_BW - 1));

  always_comb begin
    addend = '0;
    if (l_r[0]) begin
      // top bit of a two's complement multiplier carries negative weight
      addend = last ? -(eo_pkg::MUL_AW+1)'(a_r) : (eo_pkg::MUL_AW+1)'(a_r);
    end
    t     = h_r + addend;
    h_nxt = t >>> 1;
    l_nxt = {t[0], l_r[eo_pkg::MUL_BW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      h_r <= '0;
      l_r <= b;
    end else if (busy_r) begin
      h_r <= h_nxt;
      l_r <= l_nxt;
    end
  end

  assign done = done_r;
  assign p    = eo_pkg::MUL_PW'({h_r, l_r});
endmodule
`default_nettype wire

FILE: design/eo_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, gives cos/sin Q1.30.
// Depends on eo_pkg for the arctangent table and widths.
`timescale 1ns / 1ps
`default_nettype none
module eo_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] ang,
  output logic                    done,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o
);
  logic signed [eo_pkg::CW-1:0] x_r, y_r, z_r, xs, ys, at;
  logic [eo_pkg::CI_W-1:0]      i_r;
  logic                         busy_r, done_r, flip_r, fl;
  logic signed [15:0]           a2;

  always_comb begin
    fl = (ang > 16'sd16384) || (ang < -16'sd16384);
    a2 = fl ? (ang ^ 16'h8000) : ang;   // turn by pi
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = eo_pkg::atan_lut(5'(i_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + 1'b1;
        if (i_r == eo_pkg::CI_W'(eo_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= eo_pkg::CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= {{2{a2[15]}}, a2, 16'b0};
      flip_r <= fl;
    end else if (busy_r) begin
      if (!z_r[eo_pkg::CW-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  assign done  = done_r;
  assign cos_o = 32'(flip_r ? -x_r : x_r);
  assign sin_o = 32'(flip_r ? -y_r : y_r);
endmodule
`default_nettype wire

FILE: design/eo_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on eo_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module eo_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [eo_pkg::DIV_NW-1:0] num,
  input  wire logic [eo_pkg::DIV_DW-1:0] den,
  output logic                           done,
  output logic [eo_pkg::DIV_NW-1:0]      q
);
  logic [eo_pkg::DIV_NW-1:0] n_r;
  logic [eo_pkg::DIV_DW-1:0] den_r, rem_r;
  logic [eo_pkg::DIV_DW:0]   r2, diff;
  logic [eo_pkg::DIV_CW-1:0] cnt_r;
  logic                      busy_r, done_r, ge;

  always_comb begin
    r2   = {rem_r, n_r[eo_pkg::DIV_NW-1]};
    diff = r2 - {1'b0, den_r};
    ge   = (r2 >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == eo_pkg::DIV_CW'(eo_pkg::DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[eo_pkg::DIV_DW-1:0] : r2[eo_pkg::DIV_DW-1:0];
      n_r   <= {n_r[eo_pkg::DIV_NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign q    = n_r;
endmodule
`default_nettype wire

FILE: design/encoder_imu_odometry.sv
// Encoder/IMU dead-reckoning odometry: top level, sequencer and state.
// From an encoder transfer to its result: 4 sum steps, five serial multiplies, the
// CORDIC, two divides and 3 single steps (x sum, y sum, output load); a zero period
// skips the speed and rate multiplies and divides, and S_OUT waits for the output register.
// Input is taken only in S_IDLE; IMU and non-producing encoder samples stay in S_IDLE.
// Synchronous active-low reset clears pose, heading, flags and counts; scale resets to 1.
`timescale 1ns / 1ps
`default_nettype none
module encoder_imu_odometry (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire eo_pkg::eo_in_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output eo_pkg::eo_out_t     out_data,
  input  wire logic           cfg_we,
  input  wire logic [23:0]    cfg_wdata
);
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SUM   = 13'b0000000000010,
    S_MDIST = 13'b0000000000100,
    S_CORD  = 13'b0000000001000,
    S_MX    = 13'b0000000010000,
    S_AX    = 13'b0000000100000,
    S_MY    = 13'b0000001000000,
    S_AY    = 13'b0000010000000,
    S_MSPD  = 13'b0000100000000,
    S_DSPD  = 13'b0001000000000,
    S_MRATE = 13'b0010000000000,
    S_DRATE = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t             state_r;
  logic               run_r;
  logic [23:0]        mpc_r;
  logic               started_r, imu_seen_r;
  logic signed [15:0] latest_yaw_r, ref_yaw_r, last_head_r, head_r, dh_r, head_c;
  logic [31:0]        last_cnt_r [4];
  logic [31:0]        cur_r [4];
  logic [1:0]         idx_r;
  logic [23:0]        period_r;
  logic signed [eo_pkg::MUL_AW-1:0] sum_r;
  logic signed [31:0] dist_r, acc_x_r, acc_y_r, spd_r, rate_r;
  logic signed [33:0] delta_r;
  logic [eo_pkg::DIV_NW-1:0] num_r;
  logic               neg_r;
  logic               out_valid_r;
  eo_pkg::eo_out_t    out_data_r;

  logic               mul_start, mul_done, cor_start, cor_done, div_start, div_done;
  logic signed [eo_pkg::MUL_AW-1:0] mul_a;
  logic signed [eo_pkg::MUL_BW-1:0] mul_b;
  logic signed [eo_pkg::MUL_PW-1:0] prod, prod_rnd, prod_abs;
  logic signed [31:0] cos_v, sin_v, sat_q;
  logic [eo_pkg::DIV_NW-1:0] quo;
  logic signed [eo_pkg::SAT_W-1:0] qext;
  logic [31:0]        d_c;
  logic signed [eo_pkg::MUL_AW-1:0] d_ext;
  logic               out_load;

  assign in_ready = (state_r == S_IDLE);
  wire in_xfer = in_valid && in_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  eo_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(prod)
  );
  eo_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .ang(head_r),
    .done(cor_done), .cos_o(cos_v), .sin_o(sin_v)
  );
  eo_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_r), .den(period_r),
    .done(div_done), .q(quo)
  );

  always_comb begin
    head_c    = latest_yaw_r - ref_yaw_r;
    d_c       = cur_r[idx_r] - last_cnt_r[idx_r];
    d_ext     = eo_pkg::MUL_AW'($signed(d_c));
    mul_start = !run_r && (state_r == S_MDIST || state_r == S_MX || state_r == S_MY ||
                           state_r == S_MSPD || state_r == S_MRATE);
    cor_start = !run_r && (state_r == S_CORD);
    div_start = !run_r && (state_r == S_DSPD || state_r == S_DRATE);
    case (state_r)
      S_MDIST: mul_a = sum_r;
      S_MRATE: mul_a = eo_pkg::MUL_AW'(dh_r);
      default: mul_a = eo_pkg::MUL_AW'(dist_r);
    endcase
    case (state_r)
      S_MDIST: mul_b = eo_pkg::MUL_BW'({8'b0, mpc_r});
      S_MX:    mul_b = cos_v;
      S_MY:    mul_b = sin_v;
      default: mul_b = eo_pkg::US_PER_S;
    endcase
    // rounding constant: 512 for the distance scale, 2^29 for the rotation
    prod_rnd = prod + ((state_r == S_MDIST) ? eo_pkg::MUL_PW'(512)
                                            : eo_pkg::MUL_PW'(64'd536870912));
    prod_abs = prod[eo_pkg::MUL_PW-1] ? -prod : prod;
    qext     = eo_pkg::SAT_W'({16'b0, quo});
    sat_q    = eo_pkg::sat32(neg_r ? -qext : qext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      run_r        <= 1'b0;
      mpc_r        <= 24'd1;
      started_r    <= 1'b0;
      imu_seen_r   <= 1'b0;
      latest_yaw_r <= '0;
      ref_yaw_r    <= '0;
      last_head_r  <= '0;
      acc_x_r      <= '0;
      acc_y_r      <= '0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < 4; k++) last_cnt_r[k] <= '0;
    end else begin
      if (cfg_we) mpc_r <= cfg_wdata;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (mul_start || cor_start || div_start) run_r <= 1'b1;
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (!in_data.action) begin
              latest_yaw_r <= in_data.yaw;
              imu_seen_r   <= 1'b1;
            end else if (!started_r) begin
              if (imu_seen_r) begin
                last_cnt_r[0] <= in_data.count_one;
                last_cnt_r[1] <= in_data.count_two;
                last_cnt_r[2] <= in_data.count_three;
                last_cnt_r[3] <= in_data.count_four;
                ref_yaw_r     <= latest_yaw_r;
                started_r     <= 1'b1;
              end
            end else begin
              cur_r[0]    <= in_data.count_one;
              cur_r[1]    <= in_data.count_two;
              cur_r[2]    <= in_data.count_three;
              cur_r[3]    <= in_data.count_four;
              period_r    <= in_data.period_us;
              head_r      <= head_c;
              dh_r        <= head_c - last_head_r;
              last_head_r <= head_c;
              sum_r       <= '0;
              idx_r       <= '0;
              state_r     <= S_SUM;
            end
          end
        end
        S_SUM: begin
          // wheels one and two count backwards
          sum_r <= idx_r[1] ? sum_r + d_ext : sum_r - d_ext;
          last_cnt_r[idx_r] <= cur_r[idx_r];
          idx_r <= idx_r + 1'b1;
          if (idx_r == 2'd3) state_r <= S_MDIST;
        end
        S_MDIST: if (mul_done) begin
          run_r   <= 1'b0;
          dist_r  <= eo_pkg::sat32(eo_pkg::SAT_W'(prod_rnd >>> 10));
          state_r <= S_CORD;
        end
        S_CORD: if (cor_done) begin
          run_r   <= 1'b0;
          state_r <= S_MX;
        end
        S_MX: if (mul_done) begin
          run_r   <= 1'b0;
          delta_r <= 34'(prod_rnd >>> 30);
          state_r <= S_AX;
        end
        S_AX: begin
          acc_x_r <= eo_pkg::sat32(eo_pkg::SAT_W'(acc_x_r) + eo_pkg::SAT_W'(delta_r));
          state_r <= S_MY;
        end
        S_MY: if (mul_done) begin
          run_r   <= 1'b0;
          delta_r <= 34'(prod_rnd >>> 30);
          state_r <= S_AY;
        end
        S_AY: begin
          acc_y_r <= eo_pkg::sat32(eo_pkg::SAT_W'(acc_y_r) + eo_pkg::SAT_W'(delta_r));
          if (period_r == '0) begin
            spd_r   <= '0;
            rate_r  <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_MSPD;
          end
        end
        S_MSPD, S_MRATE: if (mul_done) begin
          run_r   <= 1'b0;
          num_r   <= prod_abs[eo_pkg::DIV_NW-1:0];
          neg_r   <= prod[eo_pkg::MUL_PW-1];
          state_r <= (state_r == S_MSPD) ? S_DSPD : S_DRATE;
        end
        S_DSPD: if (div_done) begin
          run_r   <= 1'b0;
          spd_r   <= sat_q;
          state_r <= S_MRATE;
        end
        S_DRATE: if (div_done) begin
          run_r   <= 1'b0;
          rate_r  <= sat_q;
          state_r <= S_OUT;
        end
        S_OUT: if (out_load) begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.pos_x        <= acc_x_r;
      out_data_r.pos_y        <= acc_y_r;
      out_data_r.heading      <= head_r;
      out_data_r.speed        <= spd_r;
      out_data_r.yaw_rate     <= rate_r;
      out_data_r.period_error <= (period_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule
`default_nettype wire

FILE: design/eo_checker.sv
// Port-level checks for encoder_imu_odometry, attached by bind.
// Depends on eo_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none
module eo_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire eo_pkg::eo_out_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.period_error |-> out_data.speed == 0 && out_data.yaw_rate == 0)
    else $error("rates not zero on period error");

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after an input transfer");
endmodule

bind encoder_imu_odometry eo_checker u_eo_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
